// ===== src/sdmhs_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the strip detector max-hit selector
package sdmhs_pkg;

    localparam int unsigned NUM_CATS  = 4;
    localparam int unsigned NUM_GAINS = 3;
    localparam int unsigned MAX_DET_CAP = 4;

    localparam int unsigned DET_W       = 2;
    localparam int unsigned STRIP_W     = 6;
    localparam int unsigned GAIN_W      = 2;
    localparam int unsigned CAT_W       = 2;
    localparam int unsigned ENERGY_W    = 16;
    localparam int unsigned OUT_TIME_W  = 48;
    localparam int unsigned CNT_W       = 8;
    localparam int unsigned ACT_DET_W   = 3;
    localparam int unsigned ACT_STRIP_W = 7;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    // command queue between front and back
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = 2;
    localparam int unsigned QCNT_W = 3;

    localparam logic FUNC_HIT   = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    localparam logic [GAIN_W-1:0] GAIN_LL  = 2'd0;
    localparam logic [GAIN_W-1:0] GAIN_HG  = 2'd1;
    localparam logic [GAIN_W-1:0] GAIN_LG  = 2'd2;
    localparam logic [GAIN_W-1:0] GAIN_UNK = 2'd3;

    localparam logic [CAT_W-1:0] CAT_BETA_FRONT = 2'd0;
    localparam logic [CAT_W-1:0] CAT_ION_FRONT  = 2'd1;
    localparam logic [CAT_W-1:0] CAT_BETA_BACK  = 2'd2;
    localparam logic [CAT_W-1:0] CAT_ION_BACK   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ACT_DET    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_STRIPS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ION_SPLIT  = 2'd2;

    localparam logic [ACT_DET_W-1:0]   ACT_DET_RESET   = 3'd1;
    localparam logic [ACT_STRIP_W-1:0] ACT_STRIP_RESET = 7'd32;
    localparam logic [ENERGY_W-1:0]    SPLIT_RESET     = 16'd10000;
    localparam logic [CNT_W-1:0]       CNT_MAX         = 8'hFF;

    typedef struct packed {
        logic                flush;
        logic [DET_W-1:0]    det;
        logic [GAIN_W-1:0]   gain;
        logic [CAT_W-1:0]    cat;
        logic [STRIP_W-1:0]  strip;
        logic [ENERGY_W-1:0] energy;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

endpackage

// ===== src/sdmhs_if.sv =====
`timescale 1ns / 1ps
// hit request and result record channel interfaces
interface sdmhs_hit_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [1:0]  detector;
    logic [5:0]  strip;
    logic [1:0]  gain_type;
    logic [15:0] energy;
    logic [47:0] time_stamp;
    logic        bad_hit;

    modport source (
        output valid, func, detector, strip, gain_type, energy, time_stamp, bad_hit,
        input  ready
    );
    modport sink (
        input  valid, func, detector, strip, gain_type, energy, time_stamp, bad_hit,
        output ready
    );
endinterface

interface sdmhs_rec_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_detector;
    logic [1:0]  category;
    logic        found;
    logic [5:0]  best_strip_out;
    logic [15:0] best_energy_out;
    logic [47:0] best_time_out;
    logic [7:0]  gain_mult;
    logic        pair_complete;
    logic        event_beta;
    logic        event_implant;
    logic        last;

    modport source (
        output valid, out_detector, category, found, best_strip_out, best_energy_out,
               best_time_out, gain_mult, pair_complete, event_beta, event_implant, last,
        input  ready
    );
    modport sink (
        input  valid, out_detector, category, found, best_strip_out, best_energy_out,
               best_time_out, gain_mult, pair_complete, event_beta, event_implant, last,
        output ready
    );
endinterface

// ===== src/sdmhs_front.sv =====
`timescale 1ns / 1ps
// front end: takes requests, drops unusable hits, picks the category
module sdmhs_front #(
    parameter int unsigned TIME_WIDTH = 48
) (
    sdmhs_hit_if.sink                                i_hit,
    input  logic                                     i_q_full,
    input  logic [sdmhs_pkg::ACT_DET_W-1:0]          i_ndet,
    input  logic [sdmhs_pkg::ACT_STRIP_W-1:0]        i_nstrips,
    input  logic [sdmhs_pkg::ENERGY_W-1:0]           i_split,
    output logic                                     o_push,
    output sdmhs_pkg::t_cmd                          o_cmd,
    output logic [TIME_WIDTH-1:0]                    o_time
);

    logic        w_keep;
    logic [63:0] w_time64;

    assign i_hit.ready = !i_q_full;

    always_comb begin
        w_keep = (i_hit.func == sdmhs_pkg::FUNC_FLUSH) ||
                 (!i_hit.bad_hit &&
                  (i_hit.gain_type != sdmhs_pkg::GAIN_UNK) &&
                  ({1'b0, i_hit.detector} < i_ndet) &&
                  ({1'b0, i_hit.strip} < i_nstrips));
    end

    assign o_push = i_hit.valid && !i_q_full && w_keep;

    always_comb begin
        o_cmd.flush  = (i_hit.func == sdmhs_pkg::FUNC_FLUSH);
        o_cmd.det    = i_hit.detector;
        o_cmd.gain   = i_hit.gain_type;
        o_cmd.strip  = i_hit.strip;
        o_cmd.energy = i_hit.energy;
        if (i_hit.gain_type == sdmhs_pkg::GAIN_LL) begin
            o_cmd.cat = (i_hit.energy < i_split) ? sdmhs_pkg::CAT_BETA_FRONT
                                                 : sdmhs_pkg::CAT_ION_FRONT;
        end else if (i_hit.gain_type == sdmhs_pkg::GAIN_HG) begin
            o_cmd.cat = sdmhs_pkg::CAT_BETA_BACK;
        end else begin
            o_cmd.cat = sdmhs_pkg::CAT_ION_BACK;
        end
    end

    // timestamp kept to the stored width
    assign w_time64 = 64'(i_hit.time_stamp);
    assign o_time   = w_time64[TIME_WIDTH-1:0];

endmodule

// ===== src/sdmhs_queue.sv =====
`timescale 1ns / 1ps
// short command queue between the front end and the store
module sdmhs_queue #(
    parameter int unsigned TIME_WIDTH = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  sdmhs_pkg::t_cmd       i_cmd,
    input  logic [TIME_WIDTH-1:0] i_time,
    input  logic                  i_pop,
    output logic                  o_full,
    output sdmhs_pkg::t_qhead     o_head,
    output logic [TIME_WIDTH-1:0] o_time
);

    sdmhs_pkg::t_cmd               r_cmd  [sdmhs_pkg::QDEPTH];
    logic [TIME_WIDTH-1:0]         r_time [sdmhs_pkg::QDEPTH];
    logic [sdmhs_pkg::QPTR_W-1:0]  r_wr;
    logic [sdmhs_pkg::QPTR_W-1:0]  r_rd;
    logic [sdmhs_pkg::QCNT_W-1:0]  r_cnt;

    assign o_full       = (r_cnt == sdmhs_pkg::QCNT_W'(sdmhs_pkg::QDEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_cmd[r_rd];
    assign o_time       = r_time[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + sdmhs_pkg::QCNT_W'(i_push) - sdmhs_pkg::QCNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_cmd[r_wr]  <= i_cmd;
            r_time[r_wr] <= i_time;
        end
    end

endmodule

// ===== src/sdmhs_back.sv =====
`timescale 1ns / 1ps
// back end: per-detector best-hit store, counters and flush record walker
module sdmhs_back #(
    parameter int unsigned NUM_DET    = 4,
    parameter int unsigned TIME_WIDTH = 48
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [sdmhs_pkg::ACT_DET_W-1:0]   i_ndet,
    input  sdmhs_pkg::t_qhead                 i_head,
    input  logic [TIME_WIDTH-1:0]             i_time,
    output logic                              o_pop,
    sdmhs_rec_if.source                       o_rec
);

    localparam int unsigned DW = (NUM_DET > 1) ? $clog2(NUM_DET) : 1;
    localparam int unsigned ACT_DET_EXT = sdmhs_pkg::ACT_DET_W;

    logic                              r_found  [NUM_DET][sdmhs_pkg::NUM_CATS];
    logic [sdmhs_pkg::ENERGY_W-1:0]    r_energy [NUM_DET][sdmhs_pkg::NUM_CATS];
    logic [sdmhs_pkg::STRIP_W-1:0]     r_strip  [NUM_DET][sdmhs_pkg::NUM_CATS];
    logic [TIME_WIDTH-1:0]             r_time   [NUM_DET][sdmhs_pkg::NUM_CATS];
    logic [sdmhs_pkg::CNT_W-1:0]       r_mult   [NUM_DET][sdmhs_pkg::NUM_GAINS];

    logic [DW-1:0]                     r_fdet;
    logic [sdmhs_pkg::CAT_W-1:0]       r_fcat;

    logic                              r_ovalid;
    logic [sdmhs_pkg::DET_W-1:0]       r_odet;
    logic [sdmhs_pkg::CAT_W-1:0]       r_ocat;
    logic                              r_ofound;
    logic [sdmhs_pkg::STRIP_W-1:0]     r_ostrip;
    logic [sdmhs_pkg::ENERGY_W-1:0]    r_oenergy;
    logic [sdmhs_pkg::OUT_TIME_W-1:0]  r_otime;
    logic [sdmhs_pkg::CNT_W-1:0]       r_omult;
    logic                              r_opair;
    logic                              r_obeta;
    logic                              r_oion;
    logic                              r_olast;

    sdmhs_pkg::t_cmd                   w_cmd;
    logic [DW-1:0]                     w_hdet;
    logic [sdmhs_pkg::CNT_W-1:0]       w_cnt;
    logic                              w_take;
    logic                              w_do_hit;
    logic                              w_do_rec;
    logic                              w_out_free;
    logic                              w_last;
    logic [sdmhs_pkg::GAIN_W-1:0]      w_rgain;
    logic                              w_rfound;
    logic                              w_rpair;
    logic                              w_any_beta;
    logic                              w_any_ion;
    logic [63:0]                       w_rtime64;

    assign w_cmd  = i_head.cmd;
    assign w_hdet = w_cmd.det[DW-1:0];

    // hit side: read-modify-write of one slot and one counter per cycle
    assign w_cnt  = r_mult[w_hdet][w_cmd.gain];
    assign w_take = !r_found[w_hdet][w_cmd.cat] ||
                    (w_cmd.energy > r_energy[w_hdet][w_cmd.cat]);

    assign w_out_free = !r_ovalid || o_rec.ready;
    assign w_do_hit   = i_head.valid && !w_cmd.flush;
    assign w_do_rec   = i_head.valid && w_cmd.flush && w_out_free;
    assign w_last     = (ACT_DET_EXT'(r_fdet) == i_ndet - 3'd1) &&
                        (r_fcat == sdmhs_pkg::CAT_ION_BACK);
    assign o_pop      = w_do_hit || (w_do_rec && w_last);

    // flush side: record fields for the slot under the walker
    assign w_rgain   = (r_fcat < sdmhs_pkg::CAT_BETA_BACK) ? sdmhs_pkg::GAIN_LL
                                                           : r_fcat - 2'd1;
    assign w_rfound  = r_found[r_fdet][r_fcat];
    assign w_rpair   = r_found[r_fdet][{1'b0, r_fcat[0]}] &&
                       r_found[r_fdet][{1'b1, r_fcat[0]}];
    assign w_rtime64 = 64'(r_time[r_fdet][r_fcat]);

    always_comb begin
        w_any_beta = 1'b0;
        w_any_ion  = 1'b0;
        for (int d = 0; d < NUM_DET; d++) begin
            if (3'(d) < i_ndet) begin
                if (r_found[d][sdmhs_pkg::CAT_BETA_FRONT] &&
                    r_found[d][sdmhs_pkg::CAT_BETA_BACK]) begin
                    w_any_beta = 1'b1;
                end
                if (r_found[d][sdmhs_pkg::CAT_ION_FRONT] &&
                    r_found[d][sdmhs_pkg::CAT_ION_BACK]) begin
                    w_any_ion = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_fdet   <= '0;
            r_fcat   <= '0;
            for (int d = 0; d < NUM_DET; d++) begin
                for (int c = 0; c < sdmhs_pkg::NUM_CATS; c++) begin
                    r_found[d][c] <= 1'b0;
                end
                for (int g = 0; g < sdmhs_pkg::NUM_GAINS; g++) begin
                    r_mult[d][g] <= '0;
                end
            end
        end else begin
            if (w_do_rec) begin
                r_ovalid <= 1'b1;
            end else if (o_rec.ready) begin
                r_ovalid <= 1'b0;
            end
            if (w_do_hit) begin
                if (w_cnt != sdmhs_pkg::CNT_MAX) begin
                    r_mult[w_hdet][w_cmd.gain] <= w_cnt + 1'b1;
                end
                if (w_take) begin
                    r_found[w_hdet][w_cmd.cat] <= 1'b1;
                end
            end
            if (w_do_rec) begin
                r_fcat <= r_fcat + 2'd1;
                if (w_last) begin
                    // end of flush: empty the store for the next event
                    r_fdet <= '0;
                    for (int d = 0; d < NUM_DET; d++) begin
                        for (int c = 0; c < sdmhs_pkg::NUM_CATS; c++) begin
                            r_found[d][c] <= 1'b0;
                        end
                        for (int g = 0; g < sdmhs_pkg::NUM_GAINS; g++) begin
                            r_mult[d][g] <= '0;
                        end
                    end
                end else if (r_fcat == sdmhs_pkg::CAT_ION_BACK) begin
                    r_fdet <= r_fdet + 1'b1;
                end
            end
        end
    end

    // payload, meaningful only under the found bits and the output valid
    always_ff @(posedge i_clk) begin
        if (w_do_hit && w_take) begin
            r_energy[w_hdet][w_cmd.cat] <= w_cmd.energy;
            r_strip[w_hdet][w_cmd.cat]  <= w_cmd.strip;
            r_time[w_hdet][w_cmd.cat]   <= i_time;
        end
        if (w_do_rec) begin
            r_odet    <= sdmhs_pkg::DET_W'(r_fdet);
            r_ocat    <= r_fcat;
            r_ofound  <= w_rfound;
            r_ostrip  <= w_rfound ? r_strip[r_fdet][r_fcat] : '0;
            r_oenergy <= w_rfound ? r_energy[r_fdet][r_fcat] : '0;
            r_otime   <= w_rfound ? w_rtime64[sdmhs_pkg::OUT_TIME_W-1:0] : '0;
            r_omult   <= r_mult[r_fdet][w_rgain];
            r_opair   <= w_rpair;
            r_obeta   <= w_last && w_any_beta;
            r_oion    <= w_last && w_any_ion;
            r_olast   <= w_last;
        end
    end

    assign o_rec.valid           = r_ovalid;
    assign o_rec.out_detector    = r_odet;
    assign o_rec.category        = r_ocat;
    assign o_rec.found           = r_ofound;
    assign o_rec.best_strip_out  = r_ostrip;
    assign o_rec.best_energy_out = r_oenergy;
    assign o_rec.best_time_out   = r_otime;
    assign o_rec.gain_mult       = r_omult;
    assign o_rec.pair_complete   = r_opair;
    assign o_rec.event_beta      = r_obeta;
    assign o_rec.event_implant   = r_oion;
    assign o_rec.last            = r_olast;

endmodule

// ===== src/strip_detector_max_hit_selector_top.sv =====
`timescale 1ns / 1ps
// top level of the strip detector max-hit selector
//
// i_hit carries one request per item: a detector hit (func 0) or an end of
// event (func 1). o_rec returns four result records per active detector for
// each end of event, ordered by detector and then category; the last one
// has last set and carries the event-wide beta and implant flags.
// Configuration goes through i_cfg_we / i_cfg_idx / i_cfg_data while the
// block is idle, which only the user enforces. Out-of-range register values
// are clamped. Hits are taken one per cycle while the queue has room: each
// is a single read-modify-write of the best-hit store and its counter in the
// back end. A request is accepted into a four-entry queue, so i_hit.ready
// drops only when that queue is full. An end of event loads its first record
// once it reaches the queue head and the output register is free, then one
// record per cycle while o_rec.ready is high. When o_rec stalls, the record
// holds in the output register and the walker waits; hits pile up in the
// queue. The store is cleared in the same cycle as the last record is
// loaded. Reset (synchronous, active low) empties the queue and the store
// and loads the register defaults: one detector, 32 strips, split at 10000.
module strip_detector_max_hit_selector_top #(
    parameter int unsigned MAX_DETECTORS = 4,
    parameter int unsigned MAX_STRIPS    = 64,
    parameter int unsigned TIME_WIDTH    = 48
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    sdmhs_hit_if.sink                           i_hit,
    sdmhs_rec_if.source                         o_rec,
    input  logic                                i_cfg_we,
    input  logic [sdmhs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sdmhs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int unsigned NCAP = (MAX_DETECTORS < sdmhs_pkg::MAX_DET_CAP) ?
                                   MAX_DETECTORS : sdmhs_pkg::MAX_DET_CAP;

    logic [sdmhs_pkg::ACT_DET_W-1:0]   r_act_det;
    logic [sdmhs_pkg::ACT_STRIP_W-1:0] r_act_strips;
    logic [sdmhs_pkg::ENERGY_W-1:0]    r_split;

    logic [sdmhs_pkg::ACT_DET_W-1:0]   w_ndet;
    logic [sdmhs_pkg::ACT_STRIP_W-1:0] w_nstrips;

    logic                              w_push;
    sdmhs_pkg::t_cmd                   w_cmd;
    logic [TIME_WIDTH-1:0]             w_time;
    logic                              w_full;
    logic                              w_pop;
    sdmhs_pkg::t_qhead                 w_head;
    logic [TIME_WIDTH-1:0]             w_head_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_det    <= sdmhs_pkg::ACT_DET_RESET;
            r_act_strips <= sdmhs_pkg::ACT_STRIP_RESET;
            r_split      <= sdmhs_pkg::SPLIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sdmhs_pkg::CFG_ACT_DET: begin
                    r_act_det <= i_cfg_data[sdmhs_pkg::ACT_DET_W-1:0];
                end
                sdmhs_pkg::CFG_ACT_STRIPS: begin
                    r_act_strips <= i_cfg_data[sdmhs_pkg::ACT_STRIP_W-1:0];
                end
                sdmhs_pkg::CFG_ION_SPLIT: begin
                    r_split <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_act_det == '0) begin
            w_ndet = 3'd1;
        end else if (r_act_det > sdmhs_pkg::ACT_DET_W'(NCAP)) begin
            w_ndet = sdmhs_pkg::ACT_DET_W'(NCAP);
        end else begin
            w_ndet = r_act_det;
        end
        if (r_act_strips == '0) begin
            w_nstrips = 7'd1;
        end else if (r_act_strips > sdmhs_pkg::ACT_STRIP_W'(MAX_STRIPS)) begin
            w_nstrips = sdmhs_pkg::ACT_STRIP_W'(MAX_STRIPS);
        end else begin
            w_nstrips = r_act_strips;
        end
    end

    sdmhs_front #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_front (
        .i_hit     (i_hit),
        .i_q_full  (w_full),
        .i_ndet    (w_ndet),
        .i_nstrips (w_nstrips),
        .i_split   (r_split),
        .o_push    (w_push),
        .o_cmd     (w_cmd),
        .o_time    (w_time)
    );

    sdmhs_queue #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_time  (w_time),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head),
        .o_time  (w_head_time)
    );

    sdmhs_back #(
        .NUM_DET    (NCAP),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ndet  (w_ndet),
        .i_head  (w_head),
        .i_time  (w_head_time),
        .o_pop   (w_pop),
        .o_rec   (o_rec)
    );

    // the queue is never written past its depth
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("command pushed into a full queue");

    // the back end only retires a command that is present
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("command popped from an empty queue");

    // the final record belongs to the last active detector's last category
    a_last_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rec.valid && o_rec.last) |->
            (o_rec.category == sdmhs_pkg::CAT_ION_BACK &&
             {1'b0, o_rec.out_detector} == w_ndet - 3'd1))
        else $error("last record at the wrong place");

    // event flags appear on the final record only
    a_event_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rec.valid && !o_rec.last) |-> (!o_rec.event_beta && !o_rec.event_implant))
        else $error("event flag set before the last record");

endmodule
